>>> hdl/seeds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Seeds automaton package
// Request codes, field widths and the birth count shared by the block's files.
// ----------------------------------------------------------------------------
package seeds_pkg;

   localparam int KIND_W = 2;
   localparam int X_W = 6;
   localparam int Y_W = 6;
   localparam int DATA_W = 64;
   localparam int BIRTH_COUNT = 2;

   typedef logic [KIND_W-1:0] req_kind_type;
   typedef logic [X_W-1:0] cell_x_type;
   typedef logic [Y_W-1:0] cell_y_type;
   typedef logic [DATA_W-1:0] row_word_type;

   localparam req_kind_type REQ_SET = 2'd0;
   localparam req_kind_type REQ_WRITE = 2'd1;
   localparam req_kind_type REQ_READ = 2'd2;
   localparam req_kind_type REQ_ADVANCE = 2'd3;

endpackage
`default_nettype wire

>>> hdl/seeds_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Seeds automaton channels
// Valid/ready channels for requests and for responses.
// ----------------------------------------------------------------------------
interface seeds_req_if;
   import seeds_pkg::*;

   logic valid;
   logic ready;
   req_kind_type req_type;
   cell_x_type cell_x;
   cell_y_type cell_y;
   row_word_type row_data;

   modport source (output valid, output req_type, output cell_x, output cell_y,
                   output row_data, input ready);
   modport sink (input valid, input req_type, input cell_x, input cell_y,
                 input row_data, output ready);
endinterface

interface seeds_rsp_if;
   import seeds_pkg::*;

   logic valid;
   logic ready;
   row_word_type read_data;

   modport source (output valid, output read_data, input ready);
   modport sink (input valid, input read_data, output ready);
endinterface
`default_nettype wire

>>> hdl/seeds_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Seeds row cell
// One grid row; takes the row of its neighbor on every clock.
// ----------------------------------------------------------------------------
module seeds_cell #(
   parameter int ROW_BITS = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [ROW_BITS-1:0] shift_in,
   output logic      [ROW_BITS-1:0] row_q
);
   logic [ROW_BITS-1:0] row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= shift_in;
      end
   end

   assign row_q = row_ff;
endmodule
`default_nettype wire

>>> hdl/seeds_rule.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Seeds rule
// Next state of one row from the old rows above, at and below it.
// ----------------------------------------------------------------------------
module seeds_rule #(
   parameter int ROW_BITS = 64
) (
   input  wire logic [ROW_BITS-1:0] above,
   input  wire logic [ROW_BITS-1:0] cur,
   input  wire logic [ROW_BITS-1:0] below,
   output logic      [ROW_BITS-1:0] next_row
);
   import seeds_pkg::*;

   logic [ROW_BITS-1:0] west_a, east_a, west_c, east_c, west_b, east_b;

   // Bit x of a west copy holds column x-1, of an east copy column x+1.
   assign west_a = {above[ROW_BITS-2:0], above[ROW_BITS-1]};
   assign east_a = {above[0], above[ROW_BITS-1:1]};
   assign west_c = {cur[ROW_BITS-2:0], cur[ROW_BITS-1]};
   assign east_c = {cur[0], cur[ROW_BITS-1:1]};
   assign west_b = {below[ROW_BITS-2:0], below[ROW_BITS-1]};
   assign east_b = {below[0], below[ROW_BITS-1:1]};

   always_comb begin
      for (int j = 0; j < ROW_BITS; j++) begin
         next_row[j] = !cur[j] &&
            ($countones({west_a[j], above[j], east_a[j], west_c[j], east_c[j],
                         west_b[j], below[j], east_b[j]}) == BIRTH_COUNT);
      end
   end
endmodule
`default_nettype wire

>>> hdl/seeds_automaton_torus_step_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Seeds automaton on a torus
// Holds a GRID_HEIGHT by GRID_WIDTH binary grid and steps it under rule B2/S.
//
// Requests arrive on req_ch (set a cell, write a row, read a row, advance one
// generation); every request gives exactly one response item on rsp_ch, which
// carries the row for a read inside the grid and zero otherwise.
// The rows sit in a ring of cells that rotates by one row every clock, so the
// row at the head changes each cycle. A set, write or read waits until its
// row reaches the head, where it is applied and its response registered.
// A request for a row outside the grid, or a set for a column outside it,
// responds in the cycle after it is taken. An advance computes one row per
// cycle at the head as the ring turns once.
// One request is in work at a time; a new one is taken once the response
// register is empty or is being emptied in the same cycle.
// When the receiver stalls, the response holds and no new request is taken.
// Reset clears every cell of the grid and leaves the block idle.
// ----------------------------------------------------------------------------
module seeds_automaton_torus_step_top #(
   parameter int GRID_WIDTH = 64,
   parameter int GRID_HEIGHT = 64
) (
   input wire logic clock,
   input wire logic reset,
   seeds_req_if.sink req_ch,
   seeds_rsp_if.source rsp_ch
);
   import seeds_pkg::*;

   localparam int ROW_W = $clog2(GRID_HEIGHT);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_HEIGHT - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SEEK = 2'd1;
   localparam logic [1:0] ST_ADV = 2'd2;

   logic [GRID_WIDTH-1:0] row_q [GRID_HEIGHT];
   logic [GRID_WIDTH-1:0] tail_in;
   logic [GRID_WIDTH-1:0] rule_above, rule_below, rule_next;

   logic [1:0] state_ff, state_in;
   logic [ROW_W-1:0] head_ff, head_in;
   logic [ROW_W-1:0] adv_cnt_ff, adv_cnt_in;
   logic [GRID_WIDTH-1:0] prev_old_ff, prev_old_in;
   logic [GRID_WIDTH-1:0] first_old_ff, first_old_in;
   req_kind_type kind_ff, kind_in;
   cell_x_type x_ff, x_in;
   cell_y_type y_ff, y_in;
   logic [GRID_WIDTH-1:0] data_ff, data_in;
   logic rsp_valid_ff, rsp_valid_in;
   row_word_type rsp_data_ff, rsp_data_in;

   logic accept;
   logic in_range;
   logic head_match;
   logic adv_last;

   for (genvar i = 0; i < GRID_HEIGHT; i++) begin : g_ring
      if (i == GRID_HEIGHT - 1) begin : g_tail
         seeds_cell #(.ROW_BITS(GRID_WIDTH)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_in (tail_in),
            .row_q    (row_q[i])
         );
      end else begin : g_body
         seeds_cell #(.ROW_BITS(GRID_WIDTH)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_in (row_q[i+1]),
            .row_q    (row_q[i])
         );
      end
   end

   seeds_rule #(.ROW_BITS(GRID_WIDTH)) u_rule (
      .above    (rule_above),
      .cur      (row_q[0]),
      .below    (rule_below),
      .next_row (rule_next)
   );

   assign req_ch.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept = req_ch.valid && req_ch.ready;
   assign in_range = (int'(req_ch.cell_y) < GRID_HEIGHT) &&
      ((req_ch.req_type != REQ_SET) || (int'(req_ch.cell_x) < GRID_WIDTH));
   assign head_match = (int'(head_ff) == int'(y_ff));
   assign adv_last = (adv_cnt_ff == LAST_ROW);

   // The row above the head is still old at the first step of a generation;
   // after that the old copy of the previous head is used.
   assign rule_above = (adv_cnt_ff == '0) ? row_q[GRID_HEIGHT-1] : prev_old_ff;
   assign rule_below = adv_last ? first_old_ff : row_q[1];

   assign head_in = (head_ff == LAST_ROW) ? '0 : head_ff + ROW_W'(1);

   always_comb begin
      state_in = state_ff;
      adv_cnt_in = adv_cnt_ff;
      prev_old_in = prev_old_ff;
      first_old_in = first_old_ff;
      kind_in = kind_ff;
      x_in = x_ff;
      y_in = y_ff;
      data_in = data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in = rsp_data_ff;
      tail_in = row_q[0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = req_ch.req_type;
               x_in = req_ch.cell_x;
               y_in = req_ch.cell_y;
               data_in = req_ch.row_data[GRID_WIDTH-1:0];
               adv_cnt_in = '0;
               if (req_ch.req_type == REQ_ADVANCE) begin
                  state_in = ST_ADV;
               end else if (in_range) begin
                  state_in = ST_SEEK;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in = '0;
               end
            end
         end
         ST_SEEK: begin
            if (head_match) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = '0;
               state_in = ST_IDLE;
               case (kind_ff)
                  REQ_SET: tail_in = row_q[0] | (GRID_WIDTH'(1) << x_ff);
                  REQ_WRITE: tail_in = data_ff;
                  REQ_READ: rsp_data_in = DATA_W'(row_q[0]);
                  default: tail_in = row_q[0];
               endcase
            end
         end
         ST_ADV: begin
            tail_in = rule_next;
            prev_old_in = row_q[0];
            if (adv_cnt_ff == '0) begin
               first_old_in = row_q[0];
            end
            adv_cnt_in = adv_cnt_ff + ROW_W'(1);
            if (adv_last) begin
               adv_cnt_in = '0;
               rsp_valid_in = 1'b1;
               rsp_data_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff <= '0;
         adv_cnt_ff <= '0;
         prev_old_ff <= '0;
         first_old_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         adv_cnt_ff <= adv_cnt_in;
         prev_old_ff <= prev_old_in;
         first_old_ff <= first_old_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      x_ff <= x_in;
      y_ff <= y_in;
      data_ff <= data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.read_data = rsp_data_ff;

   // While a request is in work the response register must be empty.
   a_busy_rsp_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("response register full while a request is in work");

   // The last step of a generation delivers its response.
   a_adv_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADV && adv_last) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("generation finished without a response");

   // A generation steps through the rows without a pause.
   a_adv_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADV && !adv_last) |=>
         (state_ff == ST_ADV && adv_cnt_ff == $past(adv_cnt_ff) + ROW_W'(1)))
      else $error("generation row count skipped or stalled");

   // A row request does not leave the seek state before its row is at the head of the ring.
   a_seek_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEEK && !head_match) |=> (state_ff == ST_SEEK))
      else $error("row request left before its row reached the head");

endmodule
`default_nettype wire
